FILE: hdl/asw_pkg.sv
// Shared types and constants for the adaptive spectral whitener.
package asw_pkg;

  localparam int unsigned MAG_W   = 24;
  localparam int unsigned COEFF_W = 16;
  localparam int unsigned BIN_W   = 10;
  localparam int unsigned FRAME_W = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned NUM_BINS_DEF = 1024;

  localparam logic [COEFF_W-1:0] COEFF_RST = 16'd65187;
  localparam logic [MAG_W-1:0]   FLOOR_RST = 24'd655;
  localparam logic [FRAME_W-1:0] FRAME_RST = 11'd512;
  localparam logic [MAG_W-1:0]   MAG_MAX   = 24'hFFFFFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF = 2'd0,
    REG_FLOOR = 2'd1,
    REG_FRAME = 2'd2
  } asw_reg_e;

  // Peak store sequencing
  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } asw_state_e;

  // Request handed from the peak update stage to the divider
  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic             oor;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] peak;
  } asw_req_t;

  // One divider pipeline stage
  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic             oor;
    logic             pass;
    logic             sat;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] dvs;
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] quo;
  } asw_div_t;

endpackage

FILE: hdl/asw_div.sv
// Pipelined restoring divider: (magnitude << 16) / peak, a setup stage then one quotient bit per stage.
module asw_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  asw_pkg::asw_req_t        req_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [asw_pkg::MAG_W-1:0] whitened_o,
  output logic [asw_pkg::BIN_W-1:0] bin_echo_o,
  output logic                     out_of_range_o
);
  import asw_pkg::*;

  localparam int unsigned NSTG = MAG_W + 1;
  localparam int unsigned FRAC = MAG_W - 16;

  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   rdy;
  asw_div_t        st_q [NSTG];
  asw_div_t        st_d [NSTG];

  // Ready ripples back from the output: a stage loads when it is empty or drains
  always_comb begin
    rdy[NSTG] = out_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign req_ready_o = rdy[0];

  // Set up: overflow test, zero divisor, initial remainder from the upper 16 magnitude bits
  always_comb begin
    st_d[0].bin  = req_i.bin;
    st_d[0].oor  = req_i.oor;
    st_d[0].mag  = req_i.mag;
    st_d[0].dvs  = req_i.peak;
    st_d[0].pass = (req_i.peak == '0);
    st_d[0].sat  = (req_i.peak != '0) &&
                   ({{FRAC{1'b0}}, req_i.mag[MAG_W-1:FRAC]} >= req_i.peak);
    st_d[0].rem  = {{FRAC{1'b0}}, req_i.mag[MAG_W-1:FRAC]};
    st_d[0].quo  = '0;
  end

  // One quotient bit per stage
  for (genvar k = 1; k < NSTG; k++) begin : g_step
    logic             dbit;
    logic [MAG_W:0]   trial;
    logic             ge;

    if (k <= FRAC) begin : g_frac
      assign dbit = st_q[k-1].mag[FRAC-k];
    end else begin : g_zero
      assign dbit = 1'b0;
    end

    assign trial = {st_q[k-1].rem, dbit};
    assign ge    = trial >= {1'b0, st_q[k-1].dvs};

    always_comb begin
      st_d[k]     = st_q[k-1];
      st_d[k].rem = ge ? MAG_W'(trial - {1'b0, st_q[k-1].dvs}) : trial[MAG_W-1:0];
      st_d[k].quo = {st_q[k-1].quo[MAG_W-2:0], ge};
    end
  end

  // Stage registers: valid bits reset, payload loads on advance
  for (genvar k = 0; k < NSTG; k++) begin : g_reg
    logic vin;
    if (k == 0) begin : g_first
      assign vin = req_valid_i;
    end else begin : g_next
      assign vin = v_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vin) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // Select the result from the last stage
  assign out_valid_o    = v_q[NSTG-1];
  assign bin_echo_o     = st_q[NSTG-1].bin;
  assign out_of_range_o = st_q[NSTG-1].oor;
  always_comb begin
    if (st_q[NSTG-1].oor) begin
      whitened_o = '0;
    end else if (st_q[NSTG-1].pass) begin
      whitened_o = st_q[NSTG-1].mag;
    end else if (st_q[NSTG-1].sat) begin
      whitened_o = MAG_MAX;
    end else begin
      whitened_o = st_q[NSTG-1].quo;
    end
  end

endmodule

FILE: hdl/adaptive_spectral_whitener_core.sv
// Top level of the adaptive spectral whitener: peak store, peak update and divider.
//
// Requests carry a bin index and a Q8.16 magnitude on a valid/ready channel;
// each yields one result (whitened value, bin echo, out-of-range flag) on a
// second valid/ready channel. A new request can be taken every cycle unless a
// clearing pass or a stall from the receiver holds it back. On acceptance the
// request loads the peak store read and the update stage register; it then
// moves into the divider setup stage, whose load writes the updated peak back,
// and 24 more stages make one quotient bit each. The peak store read bypasses
// a write-back to the same bin, so same-bin requests may follow back to back.
// Configuration writes are always taken on the cfg channel; write them only
// while the block is idle. Writing frame_bins, and leaving reset, starts a
// clearing pass that zeroes every peak store entry, during which no request
// is accepted. Reset restores the register defaults.
// When the receiver stalls, each pipeline stage holds its request and the
// stall backs up stage by stage; empty stages keep filling, so the input side
// keeps accepting until the pipeline is full.
module adaptive_spectral_whitener_core #(
  parameter int unsigned NUM_BINS = asw_pkg::NUM_BINS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [asw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [asw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [asw_pkg::BIN_W-1:0]      bin_i,
  input  logic [asw_pkg::MAG_W-1:0]      magnitude_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [asw_pkg::MAG_W-1:0]      whitened_o,
  output logic [asw_pkg::BIN_W-1:0]      bin_echo_o,
  output logic                          out_of_range_o
);
  import asw_pkg::*;

  localparam int unsigned AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BINS - 1);

  logic [COEFF_W-1:0] coeff_q;
  logic [MAG_W-1:0]   floor_q;
  logic [FRAME_W-1:0] frame_q;
  logic               cfg_wr;

  asw_state_e state_q, state_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  logic [MAG_W-1:0] mem [NUM_BINS];
  logic [MAG_W-1:0] mem_rd_q;
  logic             byp_q;
  logic [MAG_W-1:0] byp_data_q;

  logic             s1_v_q;
  logic [BIN_W-1:0] s1_bin_q;
  logic [MAG_W-1:0] s1_mag_q;
  logic             s1_oor_q;

  logic             accept;
  logic             in_oor;
  logic [AW+BIN_W-1:0] bin_ext;
  logic [AW-1:0]    rd_addr;
  logic [AW+BIN_W-1:0] s1_ext;
  logic [AW-1:0]    s1_addr;
  logic             s1_ready;
  logic             s1_leave;
  logic             div_ready;

  logic             we;
  logic [AW-1:0]    wr_addr;
  logic [MAG_W-1:0] wr_data;

  logic [MAG_W-1:0] peak;
  logic [MAG_W-1:0] diff;
  logic [MAG_W+COEFF_W-1:0] prod;
  logic [MAG_W-1:0] decayed;
  logic [MAG_W-1:0] upd;
  logic [MAG_W-1:0] new_peak;
  asw_req_t         req;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= COEFF_RST;
      floor_q <= FLOOR_RST;
      frame_q <= FRAME_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        REG_COEFF: coeff_q <= cfg_data_i[COEFF_W-1:0];
        REG_FLOOR: floor_q <= cfg_data_i[MAG_W-1:0];
        REG_FRAME: frame_q <= cfg_data_i[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // Clearing pass sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == LAST_ADDR) begin
          state_d   = ST_RUN;
          clr_cnt_d = '0;
        end
      end
      ST_RUN: ;
      default: state_d = ST_CLEAR;
    endcase
    if (cfg_wr && (cfg_index_i == REG_FRAME)) begin
      state_d   = ST_CLEAR;
      clr_cnt_d = '0;
    end
  end

  // Accept requests and flag bins outside the frame or the peak store
  assign in_ready_o = (state_q == ST_RUN) && s1_ready;
  assign accept     = in_valid_i && in_ready_o;
  assign bin_ext    = {{AW{1'b0}}, bin_i};
  assign rd_addr    = bin_ext[AW-1:0];
  assign in_oor     = ({1'b0, bin_i} >= frame_q) || (32'(bin_i) >= NUM_BINS);

  // Peak store: registered read with bypass of a same-cycle write
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      mem_rd_q   <= mem[rd_addr];
      byp_q      <= we && (wr_addr == rd_addr);
      byp_data_q <= wr_data;
    end
  end

  // Update stage register
  assign s1_ready = !s1_v_q || div_ready;
  assign s1_leave = s1_v_q && div_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_bin_q <= bin_i;
      s1_mag_q <= magnitude_i;
      s1_oor_q <= in_oor;
    end
  end

  // Decay the peak toward the magnitude, then floor it
  assign peak    = byp_q ? byp_data_q : mem_rd_q;
  assign diff    = peak - s1_mag_q;
  assign prod    = diff * coeff_q;
  assign decayed = s1_mag_q + prod[MAG_W+COEFF_W-1:COEFF_W];
  assign upd     = (s1_mag_q < peak) ? decayed : s1_mag_q;
  assign new_peak = (upd < floor_q) ? floor_q : upd;

  // Write back an in-range request on leave, or zero during the clearing pass
  assign s1_ext  = {{AW{1'b0}}, s1_bin_q};
  assign s1_addr = s1_ext[AW-1:0];
  always_comb begin
    if (state_q == ST_CLEAR) begin
      we      = 1'b1;
      wr_addr = clr_cnt_q;
      wr_data = '0;
    end else begin
      we      = s1_leave && !s1_oor_q;
      wr_addr = s1_addr;
      wr_data = new_peak;
    end
  end

  assign req.bin  = s1_bin_q;
  assign req.oor  = s1_oor_q;
  assign req.mag  = s1_mag_q;
  assign req.peak = new_peak;

  asw_div u_div (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (s1_v_q),
    .req_ready_o    (div_ready),
    .req_i          (req),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .whitened_o     (whitened_o),
    .bin_echo_o     (bin_echo_o),
    .out_of_range_o (out_of_range_o)
  );

`ifndef SYNTH
  a_frame_starts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && (cfg_index_i == REG_FRAME)) |=> (state_q == ST_CLEAR))
    else $error("frame_bins write did not start a clearing pass");

  a_run_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && (state_q == ST_RUN)) |-> (s1_leave && !s1_oor_q))
    else $error("peak store written without a leaving in-range request");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (whitened_o == '0))
    else $error("out-of-range result carries a nonzero value");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> !(s1_v_q && !$past(s1_v_q) && $past(state_q == ST_CLEAR)))
    else $error("request accepted during clearing pass");
`endif

endmodule

FILE: sim/tb_adaptive_spectral_whitener_core.sv
// Self-checking testbench for the adaptive spectral whitener core.
module tb_adaptive_spectral_whitener_core;
  import asw_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    logic [MAG_W-1:0] whitened;
    logic [BIN_W-1:0] bin;
    logic             oor;
  } white_res_t;

  typedef struct {
    logic [BIN_W-1:0] bin;
    logic [MAG_W-1:0] mag;
    bit               typed;
    logic [MAG_W-1:0] whitened;
    logic             oor;
  } stim_row_t;

  typedef struct {
    int unsigned coeff;
    int unsigned floor_val;
    int unsigned frame;
    int unsigned count;
  } phase_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [BIN_W-1:0]      bin_i = '0;
  logic [MAG_W-1:0]      magnitude_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [MAG_W-1:0]      whitened_o;
  logic [BIN_W-1:0]      bin_echo_o;
  logic                  out_of_range_o;

  // Shadow copy of the block's registers and peak memory
  logic [COEFF_W-1:0] mdl_coeff;
  logic [MAG_W-1:0]   mdl_floor;
  logic [FRAME_W-1:0] mdl_frame;
  logic [MAG_W-1:0]   mdl_peaks [NUM_BINS_DEF];

  white_res_t  pending_results[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;
  int unsigned rx_stall = 0;

  adaptive_spectral_whitener_core dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .bin_i, .magnitude_i, .out_valid_o, .out_ready_i,
    .whitened_o, .bin_echo_o, .out_of_range_o
  );

  always #5 clk_i = ~clk_i;

  // Update the shadow peak memory and compute the whitened result
  function automatic white_res_t whiten_model(logic [BIN_W-1:0] bin, logic [MAG_W-1:0] mag);
    white_res_t       res;
    logic [MAG_W-1:0] peak;
    logic [MAG_W-1:0] val;
    logic [39:0]      prod;
    logic [47:0]      quo;
    res.bin = bin;
    res.oor = (FRAME_W'(bin) >= mdl_frame);
    res.whitened = '0;
    if (!res.oor) begin
      peak = mdl_peaks[bin];
      val = mag;
      if (mag < peak) begin
        prod = 40'(peak - mag) * 40'(mdl_coeff);
        val = mag + prod[39:16];
      end
      if (val < mdl_floor) val = mdl_floor;
      mdl_peaks[bin] = val;
      if (val == '0) begin
        res.whitened = mag;
      end else begin
        quo = {mag, 16'h0} / 48'(val);
        res.whitened = (quo > 48'(MAG_MAX)) ? MAG_MAX : quo[MAG_W-1:0];
      end
    end
    return res;
  endfunction

  // Write one register and mirror it in the shadow copy
  task automatic write_reg(asw_reg_e idx, int unsigned data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_W'(data);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_COEFF: mdl_coeff = COEFF_W'(data);
      REG_FLOOR: mdl_floor = MAG_W'(data);
      REG_FRAME: begin
        mdl_frame = FRAME_W'(data);
        foreach (mdl_peaks[i]) mdl_peaks[i] = '0;
      end
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold one request until accepted; optionally insert a gap first
  task automatic send_bin(logic [BIN_W-1:0] bin, logic [MAG_W-1:0] mag,
                          bit typed, white_res_t typed_res);
    white_res_t res;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    bin_i <= bin;
    magnitude_i <= mag;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    res = whiten_model(bin, mag);
    pending_results.push_back(typed ? typed_res : res);
    @(negedge clk_i);
  endtask

  // Wait for every result, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Pick a random request, mostly for bins in use and revisiting a few hot bins
  task automatic send_random(int unsigned hold_at);
    int unsigned lim;
    int unsigned sel;
    logic [BIN_W-1:0] bin;
    logic [MAG_W-1:0] mag;
    white_res_t none;
    none = '{default: '0};
    lim = (mdl_frame > NUM_BINS_DEF) ? NUM_BINS_DEF : mdl_frame;
    sel = $urandom_range(0, 9);
    if (lim == 0 || sel >= 8) bin = BIN_W'($urandom_range(0, NUM_BINS_DEF - 1));
    else if (sel < 4) bin = BIN_W'($urandom_range(0, (lim > 8 ? 8 : lim) - 1));
    else bin = BIN_W'($urandom_range(0, lim - 1));
    case ($urandom_range(0, 5))
      0: mag = '0;
      1: mag = MAG_MAX;
      2: mag = MAG_W'($urandom_range(0, 4095));
      default: mag = MAG_W'($urandom);
    endcase
    send_bin(bin, mag, 1'b0, none);
    if (hold_at != 0) drain();
  endtask

  // Drive the result-side ready with random stall bursts
  always @(negedge clk_i) begin
    if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      rx_stall <= $urandom_range(0, 6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    white_res_t exp_res;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: bin_echo %0d whitened %h", bin_echo_o, whitened_o);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        if (whitened_o !== exp_res.whitened) begin
          $error("whitened: expected %h actual %h", exp_res.whitened, whitened_o);
          mismatches++;
        end
        if (bin_echo_o !== exp_res.bin) begin
          $error("bin_echo: expected %0d actual %0d", exp_res.bin, bin_echo_o);
          mismatches++;
        end
        if (out_of_range_o !== exp_res.oor) begin
          $error("out_of_range: expected %b actual %b", exp_res.oor, out_of_range_o);
          mismatches++;
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t   rows[$];
    phase_t      phases[$];
    white_res_t  typed_res;
    int unsigned pause_at;

    mdl_coeff = COEFF_RST;
    mdl_floor = FLOOR_RST;
    mdl_frame = FRAME_RST;
    foreach (mdl_peaks[i]) mdl_peaks[i] = '0;

    // Directed requests under reset defaults
    rows = '{
      '{10'd0,    24'h000000, 1, 24'h000000, 0},
      '{10'd511,  24'hFFFFFF, 1, 24'h010000, 0},
      '{10'd512,  24'h000005, 1, 24'h000000, 1},
      '{10'd1023, 24'hFFFFFF, 1, 24'h000000, 1},
      '{10'd511,  24'h000000, 0, 24'h0, 0},
      '{10'd511,  24'h000000, 0, 24'h0, 0},
      '{10'd511,  24'h7FFFFF, 0, 24'h0, 0},
      '{10'd511,  24'h000001, 0, 24'h0, 0},
      '{10'd0,    24'h000001, 0, 24'h0, 0},
      '{10'd0,    24'h00028F, 0, 24'h0, 0},
      '{10'd0,    24'h000290, 0, 24'h0, 0},
      '{10'd1,    24'h800000, 0, 24'h0, 0},
      '{10'd1,    24'h555555, 0, 24'h0, 0},
      '{10'd1,    24'hAAAAAA, 0, 24'h0, 0},
      '{10'd2,    24'h010000, 0, 24'h0, 0},
      '{10'd2,    24'h00FFFF, 0, 24'h0, 0},
      '{10'd341,  24'h3C3C3C, 0, 24'h0, 0},
      '{10'd682,  24'hC3C3C3, 0, 24'h0, 0}
    };

    // Register settings per phase: extremes, a random one, a zero-size frame, then reset coefficient and floor
    phases = '{
      '{0,     0,        1,    40},
      '{65535, 0,        1024, 120},
      '{65535, 16777215, 2047, 60},
      '{$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(1, 1024), 150},
      '{32768, 655,      0,    30},
      '{65187, 655,      300,  150}
    };

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      typed_res = '{whitened: rows[i].whitened, bin: rows[i].bin, oor: rows[i].oor};
      send_bin(rows[i].bin, rows[i].mag, rows[i].typed, typed_res);
    end
    drain();

    foreach (phases[p]) begin
      quiet = (p == phases.size() - 1);
      write_reg(REG_COEFF, phases[p].coeff);
      write_reg(REG_FLOOR, phases[p].floor_val);
      write_reg(REG_FRAME, phases[p].frame);
      @(negedge clk_i);
      // Zero stored peak with zero floor passes the magnitude through
      typed_res = '{default: '0};
      send_bin('0, '0, 1'b0, typed_res);
      pause_at = (p == 3) ? phases[p].count / 2 : 0;
      for (int unsigned n = 1; n <= phases[p].count; n++) begin
        send_random(n == pause_at);
      end
      drain();
    end

    if (pending_results.size() == 0 && mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/asw_pkg.sv
hdl/asw_div.sv
hdl/adaptive_spectral_whitener_core.sv
sim/tb_adaptive_spectral_whitener_core.sv
